FILE: rtl/gbfs_pkg.sv
// ----------------------------------------------------------------------------
// gbfs_pkg
// Shared types and codes for the grid breadth-first path search.
// ----------------------------------------------------------------------------
package gbfs_pkg;

  // grid store size; fixed by the 6-bit row and column fields
  localparam int MAX_ROWS = 64;
  localparam int MAX_COLS = 64;

  localparam logic [1:0] KIND_EMPTY = 2'd0;
  localparam logic [1:0] KIND_WALL  = 2'd1;
  localparam logic [1:0] KIND_START = 2'd2;
  localparam logic [1:0] KIND_GOAL  = 2'd3;

  localparam logic [1:0] RES_VISIT     = 2'd0;
  localparam logic [1:0] RES_PATH      = 2'd1;
  localparam logic [1:0] RES_FOUND     = 2'd2;
  localparam logic [1:0] RES_NOT_FOUND = 2'd3;

  localparam logic REQ_WRITE = 1'b0;
  localparam logic REQ_FETCH = 1'b1;

  localparam logic CFG_ROWS = 1'b0;
  localparam logic CFG_COLS = 1'b1;

  localparam logic [1:0] DIR_UP    = 2'd0;
  localparam logic [1:0] DIR_DOWN  = 2'd1;
  localparam logic [1:0] DIR_LEFT  = 2'd2;
  localparam logic [1:0] DIR_RIGHT = 2'd3;

  typedef enum logic [3:0] {
    ST_WAIT,
    ST_SCAN,
    ST_SCAN_END,
    ST_DEQ_RD,
    ST_DEQ,
    ST_NB_RD,
    ST_NB_CHK,
    ST_VIS_RD,
    ST_VIS_Q,
    ST_VIS_K,
    ST_PATH_RD,
    ST_PATH_CHK,
    ST_OUT
  } state_t;

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_VISIT,
    PH_PATH
  } phase_t;

endpackage

FILE: rtl/grid_bfs_path_search.sv
// ----------------------------------------------------------------------------
// grid_bfs_path_search
// Breadth-first search over a loaded grid, four neighbours, with path trace.
// ----------------------------------------------------------------------------
// Request channel (req_valid/req_stall): a write beat stores one cell kind at
// (cell_row, cell_col) and gives no result; it is dropped while a search is
// open. A fetch beat gives exactly one result beat on the result channel
// (res_valid/res_stall). The first fetch after idle runs the whole search:
// a scan of the active area, also clearing the seen map, then the BFS over
// dequeued cells and their four neighbours. A fetch then reads queue entries
// or path steps, the last read loading the result register.
// One beat is handled at a time: req_stall is high from acceptance until the
// result beat has been taken, so a stalled receiver holds the block.
// Cell store, seen map, parent directions and queue sit in single-port-read
// RAMs; every read is registered.
// Reset returns to idle with no result pending and both size registers at
// 64; grid contents are not cleared and must be written before a search.
// ----------------------------------------------------------------------------
module grid_bfs_path_search (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_we,
  input  logic       cfg_index,
  input  logic [6:0] cfg_data,
  input  logic       req_valid,
  output logic       req_stall,
  input  logic       req_type,
  input  logic [5:0] cell_row,
  input  logic [5:0] cell_col,
  input  logic [1:0] cell_kind,
  output logic       res_valid,
  input  logic       res_stall,
  output logic [1:0] out_kind,
  output logic [5:0] out_row,
  output logic [5:0] out_col,
  output logic       out_last
);
  import gbfs_pkg::*;

  localparam int RB = $clog2(MAX_ROWS);
  localparam int CB = $clog2(MAX_COLS);
  localparam int AW = RB + CB;
  localparam int RW = $clog2(MAX_ROWS + 1);
  localparam int CW = $clog2(MAX_COLS + 1);
  localparam int DEPTH = 1 << AW;

  state_t state, state_next;
  phase_t phase;

  logic [6:0]    grid_rows, grid_cols;
  logic [RW-1:0] rows_eff;
  logic [CW-1:0] cols_eff;
  logic [RB-1:0] sr;
  logic [CB-1:0] sc;
  logic          p_vld;
  logic [AW-1:0] p_addr;
  logic          has_start, has_goal, goal_found;
  logic [AW-1:0] start_cell, goal_cell, trace_cell, cur, na;
  logic [AW:0]   head, tail, vis_cnt, vis_pos;
  logic [1:0]    dir;

  // RAM ports
  logic          cs_we, sm_we, sm_wd, cf_we, q_we;
  logic [AW-1:0] cs_wa, cs_ra, sm_wa, cf_wa, q_wa, q_ra, q_wd;
  logic [1:0]    cs_wd, cs_rd, cf_rd;
  logic          sm_rd;
  logic [AW-1:0] q_rd;

  // scan result including the cell read back this cycle
  logic [AW-1:0] start_nx, goal_nx;
  logic          has_start_nx, has_goal_nx, scan_last;
  // neighbour of cur in direction dir
  logic [RB-1:0] cr;
  logic [CB-1:0] cc;
  logic          nb_ok;
  logic [AW-1:0] nb_addr;
  // parent of trace_cell
  logic [RB-1:0] tr;
  logic [CB-1:0] tcol;
  logic          pr_ok;
  logic [AW-1:0] pr_addr;
  logic          nb_take, deq_end, vis_end;

  gbfs_ram #(.WIDTH(2), .DEPTH(DEPTH)) u_cells (
    .clk, .we(cs_we), .waddr(cs_wa), .wdata(cs_wd), .raddr(cs_ra), .rdata(cs_rd));
  // seen bit read alongside the cell kind, same neighbour address
  gbfs_ram #(.WIDTH(1), .DEPTH(DEPTH)) u_seen (
    .clk, .we(sm_we), .waddr(sm_wa), .wdata(sm_wd), .raddr(nb_addr), .rdata(sm_rd));
  gbfs_ram #(.WIDTH(2), .DEPTH(DEPTH)) u_from (
    .clk, .we(cf_we), .waddr(cf_wa), .wdata(dir), .raddr(trace_cell), .rdata(cf_rd));
  gbfs_ram #(.WIDTH(AW), .DEPTH(DEPTH)) u_queue (
    .clk, .we(q_we), .waddr(q_wa), .wdata(q_wd), .raddr(q_ra), .rdata(q_rd));

  always_comb begin
    has_start_nx = has_start;
    has_goal_nx  = has_goal;
    start_nx     = start_cell;
    goal_nx      = goal_cell;
    if (p_vld && cs_rd == KIND_START) begin
      has_start_nx = 1'b1;
      start_nx     = p_addr;
    end
    if (p_vld && cs_rd == KIND_GOAL) begin
      has_goal_nx = 1'b1;
      goal_nx     = p_addr;
    end
    scan_last = (32'(sr) + 1 == 32'(rows_eff)) && (32'(sc) + 1 == 32'(cols_eff));

    cr = cur[AW-1:CB];
    cc = cur[CB-1:0];
    nb_ok   = 1'b0;
    nb_addr = cur;
    case (dir)
      DIR_UP: begin
        nb_ok   = cr != '0;
        nb_addr = {cr - 1'b1, cc};
      end
      DIR_DOWN: begin
        nb_ok   = 32'(cr) + 1 < 32'(rows_eff);
        nb_addr = {cr + 1'b1, cc};
      end
      DIR_LEFT: begin
        nb_ok   = cc != '0;
        nb_addr = {cr, cc - 1'b1};
      end
      default: begin
        nb_ok   = 32'(cc) + 1 < 32'(cols_eff);
        nb_addr = {cr, cc + 1'b1};
      end
    endcase

    // parent = child minus the step taken to reach it
    tr   = trace_cell[AW-1:CB];
    tcol = trace_cell[CB-1:0];
    pr_ok   = 1'b0;
    pr_addr = trace_cell;
    case (cf_rd)
      DIR_UP: begin
        pr_ok   = 32'(tr) + 1 < MAX_ROWS;
        pr_addr = {tr + 1'b1, tcol};
      end
      DIR_DOWN: begin
        pr_ok   = tr != '0;
        pr_addr = {tr - 1'b1, tcol};
      end
      DIR_LEFT: begin
        pr_ok   = 32'(tcol) + 1 < MAX_COLS;
        pr_addr = {tr, tcol + 1'b1};
      end
      default: begin
        pr_ok   = tcol != '0;
        pr_addr = {tr, tcol - 1'b1};
      end
    endcase

    nb_take = (cs_rd != KIND_WALL) && !sm_rd;
    deq_end = head == tail;
    vis_end = vis_pos == vis_cnt;
  end

  // next state and RAM control
  always_comb begin
    state_next = state;
    cs_we = 1'b0;
    cs_wa = {RB'(cell_row), CB'(cell_col)};
    cs_wd = cell_kind;
    cs_ra = {sr, sc};
    sm_we = 1'b0;
    sm_wa = na;
    sm_wd = 1'b1;
    cf_we = 1'b0;
    cf_wa = na;
    q_we  = 1'b0;
    q_wa  = tail[AW-1:0];
    q_wd  = na;
    q_ra  = head[AW-1:0];
    case (state)
      ST_WAIT: begin
        if (req_valid) begin
          if (req_type == REQ_WRITE) begin
            cs_we = (phase == PH_IDLE) && (32'(cell_row) < MAX_ROWS) &&
                    (32'(cell_col) < MAX_COLS);
          end else begin
            case (phase)
              PH_IDLE:  state_next = ST_SCAN;
              PH_VISIT: state_next = ST_VIS_RD;
              default:  state_next = ST_PATH_RD;
            endcase
          end
        end
      end
      ST_SCAN: begin
        sm_we = 1'b1;
        sm_wa = {sr, sc};
        sm_wd = 1'b0;
        if (scan_last) state_next = ST_SCAN_END;
      end
      ST_SCAN_END: begin
        if (has_start_nx && has_goal_nx) begin
          sm_we = 1'b1;
          sm_wa = start_nx;
          q_we  = 1'b1;
          q_wa  = '0;
          q_wd  = start_nx;
          state_next = ST_DEQ_RD;
        end else begin
          state_next = ST_OUT;
        end
      end
      ST_DEQ_RD: state_next = deq_end ? ST_VIS_RD : ST_DEQ;
      ST_DEQ: state_next = (q_rd == goal_cell) ? ST_VIS_RD : ST_NB_RD;
      ST_NB_RD: begin
        cs_ra = nb_addr;
        if (nb_ok) state_next = ST_NB_CHK;
        else if (dir == DIR_RIGHT) state_next = ST_DEQ_RD;
      end
      ST_NB_CHK: begin
        if (nb_take) begin
          sm_we = 1'b1;
          cf_we = 1'b1;
          q_we  = 1'b1;
        end
        state_next = (dir == DIR_RIGHT) ? ST_DEQ_RD : ST_NB_RD;
      end
      ST_VIS_RD: begin
        q_ra = vis_pos[AW-1:0];
        if (!vis_end) state_next = ST_VIS_Q;
        else if (goal_found) state_next = ST_PATH_RD;
        else state_next = ST_OUT;
      end
      ST_VIS_Q: begin
        cs_ra = q_rd;
        state_next = ST_VIS_K;
      end
      ST_VIS_K: state_next = (cs_rd == KIND_EMPTY) ? ST_OUT : ST_VIS_RD;
      ST_PATH_RD: begin
        cs_ra = trace_cell;
        state_next = (trace_cell == start_cell) ? ST_OUT : ST_PATH_CHK;
      end
      ST_PATH_CHK: state_next = (cs_rd == KIND_EMPTY) ? ST_OUT : ST_PATH_RD;
      ST_OUT: if (!res_stall) state_next = ST_WAIT;
      default: state_next = ST_WAIT;
    endcase
  end

  assign req_stall = state != ST_WAIT;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_WAIT;
    end else begin
      state     <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= PH_IDLE;
      res_valid  <= 1'b0;
      grid_rows  <= 7'd64;
      grid_cols  <= 7'd64;
      p_vld      <= 1'b0;
      head       <= '0;
      tail       <= '0;
      start_cell <= '0;
      goal_cell  <= '0;
      trace_cell <= '0;
      goal_found <= 1'b0;
    end else begin
      if (cfg_we) begin
        if (cfg_index == CFG_ROWS) grid_rows <= cfg_data;
        else grid_cols <= cfg_data;
      end
      p_vld  <= state == ST_SCAN;
      p_addr <= {sr, sc};
      case (state)
        ST_WAIT: begin
          if (req_valid && req_type == REQ_FETCH && phase == PH_IDLE) begin
            sr <= '0;
            sc <= '0;
            has_start  <= 1'b0;
            has_goal   <= 1'b0;
            goal_found <= 1'b0;
            head <= '0;
            tail <= '0;
            if (grid_rows == '0) rows_eff <= RW'(1);
            else if (32'(grid_rows) > MAX_ROWS) rows_eff <= RW'(MAX_ROWS);
            else rows_eff <= RW'(grid_rows);
            if (grid_cols == '0) cols_eff <= CW'(1);
            else if (32'(grid_cols) > MAX_COLS) cols_eff <= CW'(MAX_COLS);
            else cols_eff <= CW'(grid_cols);
          end
        end
        ST_SCAN: begin
          has_start  <= has_start_nx;
          has_goal   <= has_goal_nx;
          start_cell <= start_nx;
          goal_cell  <= goal_nx;
          if (32'(sc) + 1 == 32'(cols_eff)) begin
            sc <= '0;
            sr <= sr + 1'b1;
          end else begin
            sc <= sc + 1'b1;
          end
        end
        ST_SCAN_END: begin
          start_cell <= start_nx;
          goal_cell  <= goal_nx;
          if (has_start_nx && has_goal_nx) begin
            tail <= (AW+1)'(1);
          end else begin
            out_kind  <= RES_NOT_FOUND;
            out_row   <= '0;
            out_col   <= '0;
            out_last  <= 1'b1;
            res_valid <= 1'b1;
          end
        end
        ST_DEQ_RD: begin
          if (deq_end) begin
            phase   <= PH_VISIT;
            vis_cnt <= head;
            vis_pos <= '0;
          end else begin
            head <= head + 1'b1;
          end
        end
        ST_DEQ: begin
          cur <= q_rd;
          dir <= DIR_UP;
          if (q_rd == goal_cell) begin
            goal_found <= 1'b1;
            phase      <= PH_VISIT;
            vis_cnt    <= head;
            vis_pos    <= '0;
          end
        end
        ST_NB_RD: begin
          na <= nb_addr;
          if (!nb_ok) dir <= dir + 1'b1;
        end
        ST_NB_CHK: begin
          if (nb_take) tail <= tail + 1'b1;
          dir <= dir + 1'b1;
        end
        ST_VIS_RD: begin
          if (!vis_end) begin
            vis_pos <= vis_pos + 1'b1;
          end else if (goal_found) begin
            phase      <= PH_PATH;
            trace_cell <= goal_cell;
          end else begin
            phase     <= PH_IDLE;
            out_kind  <= RES_NOT_FOUND;
            out_row   <= '0;
            out_col   <= '0;
            out_last  <= 1'b1;
            res_valid <= 1'b1;
          end
        end
        ST_VIS_Q: cur <= q_rd;
        ST_VIS_K: begin
          if (cs_rd == KIND_EMPTY) begin
            out_kind  <= RES_VISIT;
            out_row   <= 6'(cur[AW-1:CB]);
            out_col   <= 6'(cur[CB-1:0]);
            out_last  <= 1'b0;
            res_valid <= 1'b1;
          end
        end
        ST_PATH_RD: begin
          if (trace_cell == start_cell) begin
            phase     <= PH_IDLE;
            out_kind  <= RES_FOUND;
            out_row   <= '0;
            out_col   <= '0;
            out_last  <= 1'b1;
            res_valid <= 1'b1;
          end
        end
        ST_PATH_CHK: begin
          // off-grid parent ends the trace
          trace_cell <= pr_ok ? pr_addr : start_cell;
          if (cs_rd == KIND_EMPTY) begin
            out_kind  <= RES_PATH;
            out_row   <= 6'(tr);
            out_col   <= 6'(tcol);
            out_last  <= 1'b0;
            res_valid <= 1'b1;
          end
        end
        ST_OUT: if (!res_stall) res_valid <= 1'b0;
        default: ;
      endcase
    end
  end

endmodule

FILE: rtl/gbfs_ram.sv
// ----------------------------------------------------------------------------
// gbfs_ram
// Simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module gbfs_ram #(
  parameter int WIDTH = 2,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: dv/grid_bfs_path_search_test.sv
// ----------------------------------------------------------------------------
// grid_bfs_path_search_test
// Self-checking bench: loads grids, runs breadth-first searches through fetch
// beats and compares every result beat with a behavioural search of its own.
// ----------------------------------------------------------------------------
module grid_bfs_path_search_test;
  import gbfs_pkg::*;

  localparam int NROW = 64;
  localparam int NCOL = 64;
  localparam int NCELL = NROW * NCOL;
  localparam int BAND = 8;
  localparam int WDOG_LIMIT = 400000;

  typedef enum int {SR_IDLE, SR_VISIT, SR_PATH, SR_DONE} srch_e;

  typedef struct packed {
    logic [1:0] kind;
    logic [5:0] row;
    logic [5:0] col;
    logic       last;
  } res_t;

  typedef struct {
    logic       t;
    logic [5:0] r;
    logic [5:0] c;
    logic [1:0] k;
    bit         typed;
    res_t       want;
  } drow_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       cfg_we = 1'b0;
  logic       cfg_index = CFG_ROWS;
  logic [6:0] cfg_data = '0;
  logic       req_valid = 1'b0;
  logic       req_stall;
  logic       req_type = REQ_WRITE;
  logic [5:0] cell_row = '0;
  logic [5:0] cell_col = '0;
  logic [1:0] cell_kind = KIND_EMPTY;
  logic       res_valid;
  logic       res_stall = 1'b0;
  logic [1:0] out_kind;
  logic [5:0] out_row;
  logic [5:0] out_col;
  logic       out_last;

  grid_bfs_path_search dut (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // behavioural copy of the block
  logic [1:0] grid_kind [NCELL];
  bit         seen [NCELL];
  logic [1:0] par_dir [NCELL];
  int         frontier [NCELL];
  int         path_cells [NCELL];
  int         fr_head, fr_tail, path_len, path_pos;
  int         start_at, goal_at;
  bit         goal_hit;
  srch_e      srch;
  logic [6:0] rows_reg = 7'd64;
  logic [6:0] cols_reg = 7'd64;

  res_t exp_res [$];
  int   errors, n_req, n_res, n_search;
  bit   quiet, hold_now;

  function automatic int clamp_dim(input logic [6:0] v, input int maxv);
    if (v < 1) return 1;
    if (v > maxv) return maxv;
    return v;
  endfunction

  function automatic void bfs_run();
    int rows, cols, cur, cr, cc, nr, nc, na, d, tr, tc, guard, tcell;
    bit has_s, has_g;
    rows = clamp_dim(rows_reg, NROW);
    cols = clamp_dim(cols_reg, NCOL);
    has_s = 0;
    has_g = 0;
    for (int r = 0; r < rows; r++)
      for (int c = 0; c < cols; c++) begin
        if (grid_kind[r*NCOL+c] == KIND_START) begin start_at = r*NCOL+c; has_s = 1; end
        if (grid_kind[r*NCOL+c] == KIND_GOAL) begin goal_at = r*NCOL+c; has_g = 1; end
      end
    goal_hit = 0;
    path_len = 0;
    path_pos = 0;
    fr_head = 0;
    fr_tail = 0;
    if (!has_s || !has_g) begin
      srch = SR_DONE;
      return;
    end
    foreach (seen[i]) seen[i] = 0;
    seen[start_at] = 1;
    frontier[fr_tail++] = start_at;
    while (fr_head < fr_tail) begin
      cur = frontier[fr_head++];
      cr = cur / NCOL;
      cc = cur % NCOL;
      if (cur == goal_at) begin goal_hit = 1; break; end
      for (d = 0; d < 4; d++) begin
        nr = cr + ((d == DIR_UP) ? -1 : (d == DIR_DOWN) ? 1 : 0);
        nc = cc + ((d == DIR_LEFT) ? -1 : (d == DIR_RIGHT) ? 1 : 0);
        if (nr < 0 || nc < 0 || nr >= rows || nc >= cols) continue;
        na = nr*NCOL + nc;
        if (grid_kind[na] == KIND_WALL || seen[na]) continue;
        seen[na] = 1;
        par_dir[na] = 2'(d);
        if (fr_tail < NCELL) frontier[fr_tail++] = na;
      end
    end
    if (goal_hit) begin
      guard = 0;
      tcell = goal_at;
      while (tcell != start_at && guard < NCELL) begin
        d = par_dir[tcell];
        tr = tcell / NCOL - ((d == DIR_UP) ? -1 : (d == DIR_DOWN) ? 1 : 0);
        tc = tcell % NCOL - ((d == DIR_LEFT) ? -1 : (d == DIR_RIGHT) ? 1 : 0);
        if (grid_kind[tcell] == KIND_EMPTY && path_len < NCELL)
          path_cells[path_len++] = tcell;
        if (tr < 0 || tc < 0 || tr >= NROW || tc >= NCOL) break;
        tcell = tr*NCOL + tc;
        guard++;
      end
    end
    fr_tail = fr_head;
    fr_head = 0;
    srch = SR_VISIT;
  endfunction

  function automatic res_t mk_res(input logic [1:0] k, input int pos, input logic l);
    res_t x;
    x.kind = k;
    x.row = 6'(pos / NCOL);
    x.col = 6'(pos % NCOL);
    x.last = l;
    return x;
  endfunction

  function automatic void predict_beat(input logic t, input logic [5:0] r, input logic [5:0] c,
                                       input logic [1:0] k);
    int pos;
    if (t == REQ_WRITE) begin
      if (srch == SR_IDLE) grid_kind[r*NCOL+c] = k;
      return;
    end
    if (srch == SR_IDLE) bfs_run();
    while (srch == SR_VISIT) begin
      if (fr_head < fr_tail) begin
        pos = frontier[fr_head++];
        if (grid_kind[pos] == KIND_EMPTY) begin
          exp_res = {exp_res, mk_res(RES_VISIT, pos, 1'b0)};
          return;
        end
      end else srch = goal_hit ? SR_PATH : SR_DONE;
    end
    if (srch == SR_PATH) begin
      if (path_pos < path_len) begin
        exp_res = {exp_res, mk_res(RES_PATH, path_cells[path_pos++], 1'b0)};
        return;
      end
      srch = SR_DONE;
    end
    exp_res = {exp_res, mk_res(goal_hit ? RES_FOUND : RES_NOT_FOUND, 0, 1'b1)};
    n_search++;
    srch = SR_IDLE;
  endfunction

  function automatic int pick_gap();
    if (quiet) return 0;
    if ($urandom_range(0, 9) == 0) return $urandom_range(5, 40);
    return $urandom_range(0, 2);
  endfunction

  task automatic send_req(input logic t, input logic [5:0] r, input logic [5:0] c,
                          input logic [1:0] k);
    int g;
    g = pick_gap();
    if (g > 0) begin
      req_valid <= 1'b0;
      repeat (g) @(posedge clk);
    end
    req_valid <= 1'b1;
    req_type <= t;
    cell_row <= r;
    cell_col <= c;
    cell_kind <= k;
    do @(posedge clk); while (req_stall);
    predict_beat(t, r, c, k);
    n_req++;
  endtask

  task automatic send_write(input logic [5:0] r, input logic [5:0] c, input logic [1:0] k);
    send_req(REQ_WRITE, r, c, k);
  endtask

  task automatic send_fetch();
    send_req(REQ_FETCH, 6'($urandom_range(0, 63)), 6'($urandom_range(0, 63)),
             2'($urandom_range(0, 3)));
  endtask

  // wait for the block to drain, then let a write still in flight finish
  task automatic drain();
    req_valid <= 1'b0;
    while (exp_res.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_cfg(input logic idx, input logic [6:0] v);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= v;
    @(posedge clk);
    if (idx == CFG_ROWS) rows_reg = v;
    else cols_reg = v;
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  function automatic logic [1:0] rand_kind();
    int x;
    x = $urandom_range(0, 99);
    if (x < 60) return KIND_EMPTY;
    if (x < 85) return KIND_WALL;
    if (x < 92) return KIND_START;
    return KIND_GOAL;
  endfunction

  function automatic logic [6:0] rand_dim();
    int x;
    x = $urandom_range(0, 9);
    if (x == 0) return 7'd0;
    if (x == 1) return 7'($urandom_range(65, 127));
    if (x == 2) return 7'd1;
    return 7'($urandom_range(1, 8));
  endfunction

  // result side: random stall bursts, one long hold-off on request
  initial begin
    int len;
    forever begin
      if (hold_now) begin
        res_stall <= 1'b1;
        repeat (600) @(posedge clk);
        hold_now = 0;
      end else begin
        res_stall <= quiet ? 1'b0 : ($urandom_range(0, 2) == 0);
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 40) : $urandom_range(1, 3);
        repeat (len) @(posedge clk);
      end
    end
  end

  always @(posedge clk) begin
    res_t want;
    if (!rst && res_valid && !res_stall) begin
      n_res++;
      if (exp_res.size() == 0) begin
        $error("result beat with nothing expected: kind %0d row %0d col %0d",
               out_kind, out_row, out_col);
        errors++;
      end else begin
        want = exp_res.pop_front();
        if (out_kind !== want.kind) begin
          $error("out_kind expected %0d got %0d", want.kind, out_kind); errors++;
        end
        if (out_row !== want.row) begin
          $error("out_row expected %0d got %0d", want.row, out_row); errors++;
        end
        if (out_col !== want.col) begin
          $error("out_col expected %0d got %0d", want.col, out_col); errors++;
        end
        if (out_last !== want.last) begin
          $error("out_last expected %0d got %0d", want.last, out_last); errors++;
        end
      end
    end
  end

  // watchdog on cycles with no beat on either channel
  always @(posedge clk) begin
    int idle_cnt;
    if (rst || (req_valid && !req_stall) || (res_valid && !res_stall)) idle_cnt = 0;
    else idle_cnt++;
    if (idle_cnt >= WDOG_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  drow_t dtab [$];

  function automatic void add_row(input logic t, input int r, input int c, input logic [1:0] k,
                                  input bit typed = 0, input logic [1:0] wk = RES_VISIT);
    drow_t d;
    d.t = t;
    d.r = 6'(r);
    d.c = 6'(c);
    d.k = k;
    d.typed = typed;
    d.want = mk_res(wk, 0, 1'b1);
    dtab = {dtab, d};
  endfunction

  initial begin
    int rows, cols, target;
    srch = SR_IDLE;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // fill the top rows and the left columns; every search area used below
    // keeps one side within this band, so no search reads an unwritten cell
    quiet = 1;
    for (int i = 0; i < NCELL; i++)
      if (i / NCOL < BAND || i % NCOL < BAND)
        send_write(6'(i / NCOL), 6'(i % NCOL), KIND_EMPTY);
    drain();
    write_cfg(CFG_ROWS, 7'(BAND));
    write_cfg(CFG_COLS, 7'd64);
    quiet = 0;

    // no start or goal yet
    add_row(REQ_FETCH, 63, 63, KIND_GOAL, 1, RES_NOT_FOUND);
    add_row(REQ_WRITE, 0, 0, KIND_START);
    add_row(REQ_WRITE, 0, 1, KIND_GOAL);
    add_row(REQ_WRITE, 7, 63, KIND_WALL);
    add_row(REQ_FETCH, 0, 0, KIND_EMPTY);
    add_row(REQ_WRITE, 0, 1, KIND_EMPTY);   // dropped, search open
    add_row(REQ_FETCH, 0, 0, KIND_EMPTY, 1, RES_FOUND);
    add_row(REQ_WRITE, 0, 1, KIND_EMPTY);   // goal gone
    add_row(REQ_FETCH, 0, 0, KIND_EMPTY, 1, RES_NOT_FOUND);
    add_row(REQ_WRITE, 7, 63, KIND_GOAL);
    add_row(REQ_WRITE, 0, 0, KIND_EMPTY);
    add_row(REQ_WRITE, 6, 63, KIND_START);
    add_row(REQ_FETCH, 63, 0, KIND_START);
    add_row(REQ_FETCH, 0, 63, KIND_WALL, 1, RES_FOUND);
    // goal two cells left of start: one path cell in between
    add_row(REQ_WRITE, 7, 63, KIND_EMPTY);
    add_row(REQ_WRITE, 6, 61, KIND_GOAL);
    for (int i = 0; i < 7; i++) add_row(REQ_FETCH, i, 63 - i, 2'(i % 4));
    add_row(REQ_FETCH, 0, 0, KIND_EMPTY, 1, RES_FOUND);

    foreach (dtab[i]) begin
      send_req(dtab[i].t, dtab[i].r, dtab[i].c, dtab[i].k);
      if (dtab[i].t == REQ_FETCH && dtab[i].typed) exp_res[$] = dtab[i].want;
    end

    target = 1300;
    for (int ph = 0; n_req < target; ph++) begin
      drain();
      quiet = (ph % 7 == 3);
      if (ph == 1) begin
        write_cfg(CFG_ROWS, 7'd64);
        write_cfg(CFG_COLS, 7'(BAND));
      end else if (ph == 2) begin
        write_cfg(CFG_ROWS, 7'd1);
        write_cfg(CFG_COLS, 7'd64);
      end else if (ph == 3) begin
        write_cfg(CFG_ROWS, 7'd64);
        write_cfg(CFG_COLS, 7'd1);
      end else if (ph == 4) begin
        write_cfg(CFG_ROWS, 7'd127);
        write_cfg(CFG_COLS, 7'd0);
      end else begin
        write_cfg(CFG_ROWS, rand_dim());
        // a tall grid stays narrow
        if (clamp_dim(rows_reg, NROW) > BAND) write_cfg(CFG_COLS, 7'($urandom_range(0, BAND)));
        else write_cfg(CFG_COLS, rand_dim());
      end
      rows = clamp_dim(rows_reg, NROW);
      cols = clamp_dim(cols_reg, NCOL);
      if (rows * cols <= 64) begin
        for (int r = 0; r < rows; r++)
          for (int c = 0; c < cols; c++) send_write(6'(r), 6'(c), rand_kind());
      end
      if ($urandom_range(0, 9) != 0) begin
        send_write(6'($urandom_range(0, rows - 1)), 6'($urandom_range(0, cols - 1)),
                   KIND_START);
        send_write(6'($urandom_range(0, rows - 1)), 6'($urandom_range(0, cols - 1)),
                   KIND_GOAL);
      end
      if ($urandom_range(0, 3) == 0)
        send_write(6'($urandom_range(0, 63)), 6'($urandom_range(0, 63)), rand_kind());
      if (ph == 2) hold_now = 1;
      do begin
        if ($urandom_range(0, 6) == 0)
          send_write(6'($urandom_range(0, 63)), 6'($urandom_range(0, 63)), rand_kind());
        send_fetch();
      end while (srch != SR_IDLE);
    end

    req_valid <= 1'b0;
    while (exp_res.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    $display("Ran %0d request beats and %0d result beats over %0d searches,",
             n_req, n_res, n_search);
    $display("with grid sizes from 1x1 up to 64 by 8 and out-of-range size values.");
    if (errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
